### rtl/gradient_noise_3d_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef GRADIENT_NOISE_3D_ASSERT_SVH
`define GRADIENT_NOISE_3D_ASSERT_SVH

// Clocked assertion, off while reset is held.
`define GN3_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define GN3_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/gn3_pkg.sv
`default_nettype none

package gn3_pkg;

    // Request and response payloads
    typedef struct packed {
        logic               req_type;
        logic [7:0]         table_index;
        logic [7:0]         table_value;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } t_req;

    typedef struct packed {
        logic signed [15:0] noise_value;
        logic               was_load;
    } t_rsp;

    // Request codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Datapath widths
    localparam int FRAC_W = 16;   // Q0.16 fraction
    localparam int T_W    = 17;   // fade weight, reaches 1.0
    localparam int CRD_W  = 18;   // signed corner offset
    localparam int GRAD_W = 19;   // gradient dot product
    localparam int LERP_W = 20;   // interpolated value

    // Clamp limits in Q3.16
    localparam logic signed [LERP_W-1:0] L_POS_ONE = 20'sd65536;
    localparam logic signed [LERP_W-1:0] L_NEG_ONE = -20'sd65536;

endpackage

`default_nettype wire

### rtl/gn3_ram.sv
`default_nettype none

// One write port, two registered read ports.
module gn3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

### rtl/gn3_fade.sv
`default_nettype none

// Quintic fade 6t^5-15t^4+10t^3, five register stages.
module gn3_fade
    import gn3_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [FRAC_W-1:0] i_t,
    output logic      [T_W-1:0]    o_f
);

    logic [15:0] r1_t;
    logic [19:0] r1_m;
    logic [31:0] r1_t2;
    logic [35:0] r2_p;
    logic [47:0] r2_t3f;
    logic [19:0] r3_c;
    logic [31:0] r3_t3;
    logic [51:0] r4_prod;
    logic [T_W-1:0] r5_f;
    logic [35:0] n3_sum;
    logic [51:0] n5_sum;

    // rounding adds
    always_comb begin
        n3_sum = r2_p + 36'd32768;
        n5_sum = r4_prod + 52'h0_8000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // t, 15 - 6t, t^2
            r1_t   <= i_t;
            r1_m   <= 20'd983040 - 20'(i_t) * 20'd6;
            r1_t2  <= 32'(i_t) * 32'(i_t);
            // t*(15-6t), t^3
            r2_p   <= 36'(r1_t) * 36'(r1_m);
            r2_t3f <= 48'(r1_t2) * 48'(r1_t);
            // c = 10 - t*(15-6t)
            r3_c   <= 20'd655360 - n3_sum[35:16];
            r3_t3  <= r2_t3f[47:16];
            // t^3 * c
            r4_prod <= 52'(r3_t3) * 52'(r3_c);
            r5_f    <= n5_sum[48:32];
        end
    end

    assign o_f = r5_f;

endmodule

`default_nettype wire

### rtl/gn3_lerp.sv
`default_nettype none

// a + round((b-a)*t), three stages. i_t is taken in the cycle after i_a/i_b.
module gn3_lerp
    import gn3_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [LERP_W-1:0] i_a,
    input  wire logic signed [LERP_W-1:0] i_b,
    input  wire logic        [T_W-1:0]    i_t,
    output logic      signed [LERP_W-1:0] o_y
);

    localparam int D_W = LERP_W + 1;
    localparam int P_W = D_W + T_W + 1;

    logic signed [LERP_W-1:0] r1_a;
    logic signed [D_W-1:0]    r1_d;
    logic signed [LERP_W-1:0] r2_a;
    logic signed [P_W-1:0]    r2_p;
    logic signed [LERP_W-1:0] r3_y;
    logic signed [P_W-1:0]    n_sum;
    logic signed [P_W-1:0]    n_shr;

    // round half up, floor shift
    always_comb begin
        n_sum = r2_p + P_W'(32768);
        n_shr = n_sum >>> 16;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a <= i_a;
            r1_d <= D_W'(i_b) - D_W'(i_a);
            r2_a <= r1_a;
            r2_p <= P_W'(r1_d) * P_W'($signed({1'b0, i_t}));
            r3_y <= r2_a + n_shr[LERP_W-1:0];
        end
    end

    assign o_y = r3_y;

endmodule

`default_nettype wire

### rtl/gradient_noise_3d.sv
`default_nettype none

// 3D improved Perlin noise, signed Q16.16 point in, signed Q1.14 sample out.
// One transaction is accepted per cycle while o_stall is low, and every
// transaction gives one result. The pipeline advances whenever the output
// register is empty or being taken. The permutation table is held in seven
// copies (one for the first hash level, two for the second, four for the
// third, two read ports each); a load transaction writes each copy as it
// passes that copy's read stage, so every sample sees exactly the loads
// accepted before it. Entries must be loaded before a sample reads them.
module gradient_noise_3d
    import gn3_pkg::*;
#(
    parameter int TABLE_SIZE = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_rsp      o_rsp
);

    localparam int IW     = $clog2(TABLE_SIZE);
    localparam int STAGES = 13;

    // index modulo TABLE_SIZE by conditional subtraction
    function automatic logic [IW-1:0] wrap(input logic [9:0] v);
        logic [10:0] r;
        r = {1'b0, v};
        for (int k = 5; k >= 0; k--) begin
            if (int'(r) >= (TABLE_SIZE << k)) begin
                r = r - 11'(TABLE_SIZE << k);
            end
        end
        return r[IW-1:0];
    endfunction

    // gradient dot product selected by the low hash nibble
    function automatic logic signed [GRAD_W-1:0] grad(
        input logic [7:0] hash,
        input logic signed [CRD_W-1:0] x,
        input logic signed [CRD_W-1:0] y,
        input logic signed [CRD_W-1:0] z
    );
        logic [3:0] h;
        logic signed [GRAD_W-1:0] gu;
        logic signed [GRAD_W-1:0] gv;
        h  = hash[3:0];
        gu = (h < 4'd8) ? GRAD_W'(x) : GRAD_W'(y);
        if (h < 4'd4) begin
            gv = GRAD_W'(y);
        end else if (h == 4'd12 || h == 4'd14) begin
            gv = GRAD_W'(x);
        end else begin
            gv = GRAD_W'(z);
        end
        if (h[0]) gu = -gu;
        if (h[1]) gv = -gv;
        return gu + gv;
    endfunction

    // pipeline control
    logic w_en;
    logic w_acc;
    logic w_ld_in;
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] r_ld;
    logic r_out_valid;
    t_rsp r_out;

    assign w_en    = !r_out_valid || !i_stall;
    assign o_stall = !w_en;
    assign w_acc   = i_valid && w_en;
    assign w_ld_in = (i_req.req_type == REQ_LOAD);

    // stage 1: first hash level read, or first-copy write
    logic [7:0] w_cx;
    logic [7:0] p_cx;
    logic [7:0] p_cx1;
    assign w_cx = i_req.coord_x[23:16];

    gn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram1 (
        .i_clk(i_clk),
        .i_we(w_acc && w_ld_in),
        .i_waddr(wrap({2'b00, i_req.table_index})),
        .i_wdata(i_req.table_value),
        .i_re(w_en),
        .i_raddr_a(wrap({2'b00, w_cx})),
        .i_raddr_b(wrap(10'(w_cx) + 10'd1)),
        .o_rdata_a(p_cx),
        .o_rdata_b(p_cx1)
    );

    logic [7:0]        r1_cy, r1_cz;
    logic [FRAC_W-1:0] r1_fx, r1_fy, r1_fz;
    logic [IW-1:0]     r1_idx;
    logic [7:0]        r1_val;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_cy  <= i_req.coord_y[23:16];
            r1_cz  <= i_req.coord_z[23:16];
            r1_fx  <= i_req.coord_x[15:0];
            r1_fy  <= i_req.coord_y[15:0];
            r1_fz  <= i_req.coord_z[15:0];
            r1_idx <= wrap({2'b00, i_req.table_index});
            r1_val <= i_req.table_value;
        end
    end

    // stage 2: second hash level
    logic [9:0] w_a, w_b;
    logic [7:0] p_a, p_a1, p_b, p_b1;
    logic       w_we2;
    assign w_a   = 10'(p_cx) + 10'(r1_cy);
    assign w_b   = 10'(p_cx1) + 10'(r1_cy);
    assign w_we2 = w_en && r_vld[0] && r_ld[0];

    gn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram2a (
        .i_clk(i_clk), .i_we(w_we2), .i_waddr(r1_idx), .i_wdata(r1_val),
        .i_re(w_en), .i_raddr_a(wrap(w_a)), .i_raddr_b(wrap(w_a + 10'd1)),
        .o_rdata_a(p_a), .o_rdata_b(p_a1)
    );

    gn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram2b (
        .i_clk(i_clk), .i_we(w_we2), .i_waddr(r1_idx), .i_wdata(r1_val),
        .i_re(w_en), .i_raddr_a(wrap(w_b)), .i_raddr_b(wrap(w_b + 10'd1)),
        .o_rdata_a(p_b), .o_rdata_b(p_b1)
    );

    logic [7:0]        r2_cz;
    logic [FRAC_W-1:0] r2_fx, r2_fy, r2_fz;
    logic [IW-1:0]     r2_idx;
    logic [7:0]        r2_val;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_cz  <= r1_cz;
            r2_fx  <= r1_fx;
            r2_fy  <= r1_fy;
            r2_fz  <= r1_fz;
            r2_idx <= r1_idx;
            r2_val <= r1_val;
        end
    end

    // stage 3: corner hashes
    logic [9:0] w_aa, w_ab, w_ba, w_bb;
    logic [7:0] h_aa, h_aa1, h_ab, h_ab1, h_ba, h_ba1, h_bb, h_bb1;
    logic       w_we3;
    assign w_aa  = 10'(p_a)  + 10'(r2_cz);
    assign w_ab  = 10'(p_a1) + 10'(r2_cz);
    assign w_ba  = 10'(p_b)  + 10'(r2_cz);
    assign w_bb  = 10'(p_b1) + 10'(r2_cz);
    assign w_we3 = w_en && r_vld[1] && r_ld[1];

    gn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram3a (
        .i_clk(i_clk), .i_we(w_we3), .i_waddr(r2_idx), .i_wdata(r2_val),
        .i_re(w_en), .i_raddr_a(wrap(w_aa)), .i_raddr_b(wrap(w_aa + 10'd1)),
        .o_rdata_a(h_aa), .o_rdata_b(h_aa1)
    );

    gn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram3b (
        .i_clk(i_clk), .i_we(w_we3), .i_waddr(r2_idx), .i_wdata(r2_val),
        .i_re(w_en), .i_raddr_a(wrap(w_ab)), .i_raddr_b(wrap(w_ab + 10'd1)),
        .o_rdata_a(h_ab), .o_rdata_b(h_ab1)
    );

    gn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram3c (
        .i_clk(i_clk), .i_we(w_we3), .i_waddr(r2_idx), .i_wdata(r2_val),
        .i_re(w_en), .i_raddr_a(wrap(w_ba)), .i_raddr_b(wrap(w_ba + 10'd1)),
        .o_rdata_a(h_ba), .o_rdata_b(h_ba1)
    );

    gn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram3d (
        .i_clk(i_clk), .i_we(w_we3), .i_waddr(r2_idx), .i_wdata(r2_val),
        .i_re(w_en), .i_raddr_a(wrap(w_bb)), .i_raddr_b(wrap(w_bb + 10'd1)),
        .o_rdata_a(h_bb), .o_rdata_b(h_bb1)
    );

    logic [FRAC_W-1:0] r3_fx, r3_fy, r3_fz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_fx <= r2_fx;
            r3_fy <= r2_fy;
            r3_fz <= r2_fz;
        end
    end

    // stage 4: corner gradients
    logic signed [CRD_W-1:0] w_x0, w_x1, w_y0, w_y1, w_z0, w_z1;
    logic signed [GRAD_W-1:0] r4_g [8];

    assign w_x0 = $signed({2'b00, r3_fx});
    assign w_y0 = $signed({2'b00, r3_fy});
    assign w_z0 = $signed({2'b00, r3_fz});
    assign w_x1 = w_x0 - 18'sd65536;
    assign w_y1 = w_y0 - 18'sd65536;
    assign w_z1 = w_z0 - 18'sd65536;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_g[0] <= grad(h_aa,  w_x0, w_y0, w_z0);
            r4_g[1] <= grad(h_ba,  w_x1, w_y0, w_z0);
            r4_g[2] <= grad(h_ab,  w_x0, w_y1, w_z0);
            r4_g[3] <= grad(h_bb,  w_x1, w_y1, w_z0);
            r4_g[4] <= grad(h_aa1, w_x0, w_y0, w_z1);
            r4_g[5] <= grad(h_ba1, w_x1, w_y0, w_z1);
            r4_g[6] <= grad(h_ab1, w_x0, w_y1, w_z1);
            r4_g[7] <= grad(h_bb1, w_x1, w_y1, w_z1);
        end
    end

    // fade weights, ready after stage 5
    logic [T_W-1:0] w_fu, w_fv, w_fw;

    gn3_fade u_fade_x (.i_clk(i_clk), .i_en(w_en), .i_t(i_req.coord_x[15:0]), .o_f(w_fu));
    gn3_fade u_fade_y (.i_clk(i_clk), .i_en(w_en), .i_t(i_req.coord_y[15:0]), .o_f(w_fv));
    gn3_fade u_fade_z (.i_clk(i_clk), .i_en(w_en), .i_t(i_req.coord_z[15:0]), .o_f(w_fw));

    // align v and w with the later lerp levels
    logic [T_W-1:0] r_vd [3];
    logic [T_W-1:0] r_wd [6];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vd[0] <= w_fv;
            r_vd[1] <= r_vd[0];
            r_vd[2] <= r_vd[1];
            r_wd[0] <= w_fw;
            r_wd[1] <= r_wd[0];
            r_wd[2] <= r_wd[1];
            r_wd[3] <= r_wd[2];
            r_wd[4] <= r_wd[3];
            r_wd[5] <= r_wd[4];
        end
    end

    // stages 5-7: lerp along x
    logic signed [LERP_W-1:0] w_lx0, w_lx1, w_lx2, w_lx3;

    gn3_lerp u_lx0 (.i_clk(i_clk), .i_en(w_en), .i_a(LERP_W'(r4_g[0])),
                    .i_b(LERP_W'(r4_g[1])), .i_t(w_fu), .o_y(w_lx0));
    gn3_lerp u_lx1 (.i_clk(i_clk), .i_en(w_en), .i_a(LERP_W'(r4_g[2])),
                    .i_b(LERP_W'(r4_g[3])), .i_t(w_fu), .o_y(w_lx1));
    gn3_lerp u_lx2 (.i_clk(i_clk), .i_en(w_en), .i_a(LERP_W'(r4_g[4])),
                    .i_b(LERP_W'(r4_g[5])), .i_t(w_fu), .o_y(w_lx2));
    gn3_lerp u_lx3 (.i_clk(i_clk), .i_en(w_en), .i_a(LERP_W'(r4_g[6])),
                    .i_b(LERP_W'(r4_g[7])), .i_t(w_fu), .o_y(w_lx3));

    // stages 8-10: lerp along y
    logic signed [LERP_W-1:0] w_ly0, w_ly1;

    gn3_lerp u_ly0 (.i_clk(i_clk), .i_en(w_en), .i_a(w_lx0), .i_b(w_lx1),
                    .i_t(r_vd[2]), .o_y(w_ly0));
    gn3_lerp u_ly1 (.i_clk(i_clk), .i_en(w_en), .i_a(w_lx2), .i_b(w_lx3),
                    .i_t(r_vd[2]), .o_y(w_ly1));

    // stages 11-13: lerp along z
    logic signed [LERP_W-1:0] w_lz;

    gn3_lerp u_lz (.i_clk(i_clk), .i_en(w_en), .i_a(w_ly0), .i_b(w_ly1),
                   .i_t(r_wd[5]), .o_y(w_lz));

    // clamp to [-1,1] and round to Q1.14
    logic signed [LERP_W-1:0] w_clamp;
    logic signed [LERP_W-1:0] w_rsum;
    logic signed [LERP_W-1:0] w_rshr;
    t_rsp n_out;

    always_comb begin
        priority if (w_lz > L_POS_ONE) begin
            w_clamp = L_POS_ONE;
        end else if (w_lz < L_NEG_ONE) begin
            w_clamp = L_NEG_ONE;
        end else begin
            w_clamp = w_lz;
        end
        w_rsum = w_clamp + 20'sd2;
        w_rshr = w_rsum >>> 2;
        n_out.was_load    = r_ld[STAGES-1];
        n_out.noise_value = r_ld[STAGES-1] ? 16'sd0 : w_rshr[15:0];
    end

    // valid and load flags travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[STAGES-2:0], w_acc};
            r_out_valid <= r_vld[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ld  <= {r_ld[STAGES-2:0], w_ld_in};
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

`default_nettype wire

### rtl/gn3_checker.sv
`default_nettype none

`include "gradient_noise_3d_assert.svh"

// Port-level checks for the noise block.
module gn3_checker
    import gn3_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_stall,
    input wire t_req i_req,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire t_rsp o_rsp
);

    // output side holds while stalled
    `GN3_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid, "result dropped under stall")
    `GN3_ASSERT(a_out_stable, o_valid && i_stall |=> $stable(o_rsp), "result changed under stall")

    // pipeline only backs up when the result register is blocked
    `GN3_ASSERT(a_no_false_stall, !(o_valid && i_stall) |-> !o_stall, "input stalled with free output")

    // load acknowledgements carry no sample
    `GN3_ASSERT(a_load_zero, o_valid && o_rsp.was_load |-> o_rsp.noise_value == 16'sd0, "load result not zero")

    // nothing comes out right after reset
    `GN3_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "valid after reset")

endmodule

bind gradient_noise_3d gn3_checker u_gn3_checker (.*);

`default_nettype wire

### dv/tb_gradient_noise_3d.sv
`default_nettype none

module tb_gradient_noise_3d;
    import gn3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PERM_SIZE  = 256;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYC  = 40;
    localparam int N_RANDOM   = 131;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_rsp o_rsp;

    gradient_noise_3d DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_rsp  (o_rsp)
    );

    // Predictor's copy of the permutation table and the queue of expected results
    logic [7:0] perm_copy [PERM_SIZE];
    t_rsp       pending_rsp[$];
    int         mismatch_cnt;
    int         idle_cycles;
    bit         stim_done;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Quintic fade, Q0.16 in, Q0.16 out (may reach 65536)
    function automatic longint fade_weight(input longint t);
        longint c;
        longint t3;
        c  = (64'd10 << 16) - ((t * (15 * 65536 - 6 * t) + 32768) >>> 16);
        t3 = (t * t * t) >>> 16;
        return (t3 * c + (64'd1 << 31)) >>> 32;
    endfunction

    function automatic longint grad_dot(input int hash, input longint x, input longint y,
                                        input longint z);
        int h;
        longint u;
        longint v;
        h = hash & 15;
        u = (h < 8) ? x : y;
        v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
        return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
    endfunction

    // >>> on longint is arithmetic, i.e. floor division by 2^16
    function automatic longint lerp_q16(input longint a, input longint b, input longint t);
        return a + (((b - a) * t + 32768) >>> 16);
    endfunction

    function automatic int perm_rd(input int idx);
        return int'(perm_copy[idx % PERM_SIZE]);
    endfunction

    function automatic t_rsp predict_noise(input t_req rq);
        t_rsp   rsp;
        int     cx, cy, cz, a, aa, ab, b, ba, bb;
        longint fx, fy, fz, u, v, w, r;
        longint g[8];
        longint x0, x1, x2, x3, y0, y1;
        rsp = '0;
        if (rq.req_type == REQ_LOAD) begin
            perm_copy[rq.table_index] = rq.table_value;
            rsp.was_load = 1'b1;
            return rsp;
        end
        cx = (rq.coord_x >>> 16) & 255;
        cy = (rq.coord_y >>> 16) & 255;
        cz = (rq.coord_z >>> 16) & 255;
        fx = longint'(rq.coord_x[15:0]);
        fy = longint'(rq.coord_y[15:0]);
        fz = longint'(rq.coord_z[15:0]);
        u = fade_weight(fx);
        v = fade_weight(fy);
        w = fade_weight(fz);
        a  = perm_rd(cx) + cy;
        aa = perm_rd(a) + cz;
        ab = perm_rd(a + 1) + cz;
        b  = perm_rd(cx + 1) + cy;
        ba = perm_rd(b) + cz;
        bb = perm_rd(b + 1) + cz;
        g[0] = grad_dot(perm_rd(aa), fx, fy, fz);
        g[1] = grad_dot(perm_rd(ba), fx - 65536, fy, fz);
        g[2] = grad_dot(perm_rd(ab), fx, fy - 65536, fz);
        g[3] = grad_dot(perm_rd(bb), fx - 65536, fy - 65536, fz);
        g[4] = grad_dot(perm_rd(aa + 1), fx, fy, fz - 65536);
        g[5] = grad_dot(perm_rd(ba + 1), fx - 65536, fy, fz - 65536);
        g[6] = grad_dot(perm_rd(ab + 1), fx, fy - 65536, fz - 65536);
        g[7] = grad_dot(perm_rd(bb + 1), fx - 65536, fy - 65536, fz - 65536);
        x0 = lerp_q16(g[0], g[1], u);
        x1 = lerp_q16(g[2], g[3], u);
        x2 = lerp_q16(g[4], g[5], u);
        x3 = lerp_q16(g[6], g[7], u);
        y0 = lerp_q16(x0, x1, v);
        y1 = lerp_q16(x2, x3, v);
        r  = lerp_q16(y0, y1, w);
        if (r > 65536) r = 65536;
        if (r < -65536) r = -65536;
        r = (r + 2) >>> 2;
        rsp.noise_value = r[15:0];
        return rsp;
    endfunction

    // Directed rows; a load row has a fixed acknowledgment
    typedef struct {
        t_req rq;
        bit   has_fixed;
        t_rsp fixed_rsp;
    } t_row;

    t_row dir_rows[$];

    function automatic t_req mk_sample(input int x, input int y, input int z);
        t_req rq;
        rq = '0;
        rq.req_type = REQ_SAMPLE;
        rq.coord_x = x;
        rq.coord_y = y;
        rq.coord_z = z;
        rq.table_index = 8'($urandom);
        rq.table_value = 8'($urandom);
        return rq;
    endfunction

    function automatic t_req mk_load(input int idx, input int val);
        t_req rq;
        rq = '0;
        rq.req_type = REQ_LOAD;
        rq.table_index = 8'(idx);
        rq.table_value = 8'(val);
        rq.coord_x = $urandom;
        rq.coord_y = $urandom;
        rq.coord_z = $urandom;
        return rq;
    endfunction

    // Send one transaction and hold it until accepted
    task automatic send_req(input t_req rq, input bit has_fixed, input t_rsp fixed_rsp);
        t_rsp exp_rsp;
        i_valid <= 1'b1;
        i_req   <= rq;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        exp_rsp = predict_noise(rq);
        if (has_fixed && exp_rsp != fixed_rsp) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("table row disagrees with predictor: expected %h, predicted %h",
                         fixed_rsp, exp_rsp);
        end
        pending_rsp.push_back(exp_rsp);
    endtask

    task automatic idle_gap(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Receiver stall pattern: phases of none, light and heavy stalling
    int stall_mode;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_mode <= 0;
        end else begin
            if ($urandom_range(63) == 0) stall_mode <= $urandom_range(2);
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(3) == 0);
                default: i_stall <= ($urandom_range(3) != 0);
            endcase
        end
    end

    // Result check
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rsp.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result %h", o_rsp);
            end else begin
                exp_rsp = pending_rsp.pop_front();
                if (o_rsp.noise_value !== exp_rsp.noise_value ||
                    o_rsp.was_load !== exp_rsp.was_load) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected noise=%0d load=%0b, got noise=%0d load=%0b",
                                 exp_rsp.noise_value, exp_rsp.was_load,
                                 o_rsp.noise_value, o_rsp.was_load);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction accepted and no result taken
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT && !stim_done) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        t_rsp load_ack;
        t_req rq;
        int   burst;
        int   wait_cnt;
        bit   done_ok;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        i_stall = 1'b0;
        mismatch_cnt = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        foreach (perm_copy[k]) perm_copy[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the table with a random shuffle so no sample reads an unwritten entry
        for (int k = 0; k < PERM_SIZE; k++) perm_copy[k] = 8'(k);
        for (int k = PERM_SIZE - 1; k > 0; k--) begin
            int j;
            logic [7:0] tmp;
            j = $urandom_range(k);
            tmp = perm_copy[k];
            perm_copy[k] = perm_copy[j];
            perm_copy[j] = tmp;
        end
        @(posedge i_clk);
        load_ack = '0;
        load_ack.was_load = 1'b1;
        for (int k = 0; k < PERM_SIZE; k++)
            send_req(mk_load(k, perm_copy[k]), 1'b1, load_ack);

        // Directed table: extreme loads and extreme coordinates
        dir_rows.push_back('{mk_load(8'hFF, 8'hFF), 1'b1, load_ack});
        dir_rows.push_back('{mk_load(8'h00, 8'h00), 1'b1, load_ack});
        dir_rows.push_back('{mk_sample(0, 0, 0), 1'b1, '0});
        dir_rows.push_back('{mk_sample(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0, '0});
        dir_rows.push_back('{mk_sample(32'h80000000, 32'h80000000, 32'h80000000), 1'b0, '0});
        dir_rows.push_back('{mk_sample(32'hFFFFFFFF, 0, 32'h80000000), 1'b0, '0});
        dir_rows.push_back('{mk_sample(32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF), 1'b0, '0});
        dir_rows.push_back('{mk_sample(32'h00008000, 32'h00008000, 32'h00008000), 1'b0, '0});
        dir_rows.push_back('{mk_sample(32'h00FF8000, 32'hFF004000, 32'h0001C000), 1'b0, '0});
        dir_rows.push_back('{mk_sample(32'h00010000, 32'h00020000, 32'h00030000), 1'b0, '0});
        dir_rows.push_back('{mk_sample(32'hFFFF0001, 32'h7FFF0001, 32'h5555AAAA), 1'b0, '0});
        dir_rows.push_back('{mk_load(8'hAA, 8'h55), 1'b1, load_ack});
        dir_rows.push_back('{mk_sample(32'h00AA1234, 32'h00551234, 32'h00AA4321), 1'b0, '0});
        foreach (dir_rows[k])
            send_req(dir_rows[k].rq, dir_rows[k].has_fixed, dir_rows[k].fixed_rsp);

        // Hold off until the pipeline has drained
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);

        // Random part: mostly samples, some table reloads, bursts and gaps
        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
                if ($urandom_range(9) == 0)
                    rq = mk_load($urandom, $urandom);
                else if ($urandom_range(7) == 0)
                    rq = mk_sample($urandom & 32'h8001FFFF, $urandom | 32'h7FFE0000,
                                   $urandom);
                else
                    rq = mk_sample($urandom, $urandom, $urandom);
                send_req(rq, 1'b0, '0);
            end
            if ($urandom_range(2) != 0) idle_gap($urandom_range(1, 12));
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;

        // Drain
        wait_cnt = 0;
        while (pending_rsp.size() != 0 && wait_cnt < IDLE_LIMIT) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        done_ok = (pending_rsp.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (done_ok && mismatch_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
